@@ design/symbol_hash_table_lookup_insert_macros.svh @@
// Assertion macros used by the symbol table design file.
`ifndef SYMBOL_HASH_TABLE_LOOKUP_INSERT_MACROS_SVH
`define SYMBOL_HASH_TABLE_LOOKUP_INSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define SHT_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property on every rising clock edge, reset cycles included.
`define SHT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/symhash_pkg.sv @@
package symhash_pkg;

  localparam int BYTE_BITS = 8;
  localparam int NAME_IN_W = 64;
  localparam int STATUS_W  = 2;
  localparam int INDEX_W   = 8;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_FOUND   = 2'd0;
  localparam status_t ST_CREATED = 2'd1;
  localparam status_t ST_ABSENT  = 2'd2;
  localparam status_t ST_FULL    = 2'd3;

endpackage

@@ design/symbol_hash_table_lookup_insert.sv @@
// Symbol table lookup and insert over a chained hash table.
// The input channel (in_valid, in_stall, in_symbol_name, in_create_if_absent)
// carries one name word per lookup. Only the low NAME_BYTES bytes of the name
// take part; the first character sits in the low byte. The result channel
// (out_valid, out_stall, out_status, out_entry_index) returns exactly one word
// per lookup: found, newly created, absent or table full, with the entry index.
// The name is hashed one byte per cycle into a byte sum, the SUM_W-bit sum
// (11 bits by default) is reduced modulo BUCKET_COUNT one bit per cycle,
// the bucket head is read in states S_HEAD and S_HEADW, and every chain entry
// is compared one name byte per cycle. An insert writes the name one byte per
// cycle. The byte-wide name port of the entry memory sets this pace. One
// lookup is in flight at a time; the next word is taken at the earliest in
// the cycle after the result moves into the output register, so a new lookup
// is not accepted before the last one is through.
// After reset the bucket heads are cleared one bucket per cycle; in_stall stays
// high during that pass. When the receiver stalls, the result word is held
// unchanged, and a finished lookup waits for the output register to free up
// before the block returns to accept input.
`include "symbol_hash_table_lookup_insert_macros.svh"

module symbol_hash_table_lookup_insert
  import symhash_pkg::*;
#(
  parameter int NAME_BYTES   = 8,
  parameter int BUCKET_COUNT = 64,
  parameter int ENTRY_COUNT  = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [NAME_IN_W-1:0] in_symbol_name,
  input  logic                 in_create_if_absent,
  output logic                 out_valid,
  input  logic                 out_stall,
  output status_t              out_status,
  output logic [INDEX_W-1:0]   out_entry_index
);

  localparam int NAME_W   = NAME_BYTES * BYTE_BITS;
  localparam int SUM_W    = $clog2(NAME_BYTES * 255 + 1);
  localparam int STEP_W   = $clog2(SUM_W + 1);
  localparam int BYTE_W   = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
  localparam int BKT_W    = $clog2(BUCKET_COUNT);
  localparam int IDX_W    = $clog2(ENTRY_COUNT);
  localparam int USED_W   = $clog2(ENTRY_COUNT + 1);
  localparam int NM_DEPTH = ENTRY_COUNT * (2 ** BYTE_W);
  localparam int LINK_W   = IDX_W + 1;

  // Controller states.
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SUM   = 4'd2;
  localparam logic [3:0] S_MOD   = 4'd3;
  localparam logic [3:0] S_HEAD  = 4'd4;
  localparam logic [3:0] S_HEADW = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_MISS  = 4'd7;
  localparam logic [3:0] S_INS   = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  // A link is a valid bit above an entry index.
  typedef logic [LINK_W-1:0] link_t;

  // Memories.
  link_t                bkt_mem [BUCKET_COUNT];
  link_t                nxt_mem [ENTRY_COUNT];
  logic [BYTE_BITS-1:0] nm_mem  [NM_DEPTH];

  // Control registers.
  logic [3:0]        state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [BKT_W-1:0]  clr_r, clr_nxt;
  logic [USED_W-1:0] used_r, used_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Datapath registers.
  logic [NAME_W-1:0] name_r, name_nxt;
  logic              create_r, create_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [BKT_W-1:0]  bkt_r, bkt_nxt;
  link_t             cur_r, cur_nxt;
  logic              mis_r, mis_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [IDX_W-1:0]  res_idx_r, res_idx_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [INDEX_W-1:0] out_index_r, out_index_nxt;

  // Memory read data.
  link_t                bkt_rd_r;
  link_t                nxt_rd_r;
  logic [BYTE_BITS-1:0] nm_rd_r;

  // Memory write controls.
  logic                      bkt_we;
  logic [BKT_W-1:0]          bkt_wa;
  link_t                     bkt_wd;
  logic                      nxt_we;
  logic                      nm_we;
  logic [IDX_W+BYTE_W-1:0]   nm_ra;
  logic [IDX_W+BYTE_W-1:0]   nm_wa;

  logic [NAME_W-1:0]         name_rot;
  logic [BKT_W:0]            rem_sh;
  logic                      byte_ne;
  logic                      out_free;
  logic [IDX_W-1:0]          used_idx;
  logic [IDX_W+INDEX_W-1:0]  idx_wide;

  assign used_idx = used_r[IDX_W-1:0];
  assign name_rot = (name_r >> BYTE_BITS) | (name_r << (NAME_W - BYTE_BITS));
  assign rem_sh   = {bkt_r, sum_r[SUM_W-1]};
  assign byte_ne  = (nm_rd_r != name_r[BYTE_BITS-1:0]);
  assign out_free = !out_valid_r || !out_stall;
  assign idx_wide = {{INDEX_W{1'b0}}, res_idx_r};
  assign nm_ra    = {cur_r[IDX_W-1:0], cnt_r[BYTE_W-1:0]};
  assign nm_wa    = {used_idx, cnt_r[BYTE_W-1:0]};

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_index = out_index_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    clr_nxt        = clr_r;
    used_nxt       = used_r;
    out_valid_nxt  = out_valid_r && out_stall;
    name_nxt       = name_r;
    create_nxt     = create_r;
    sum_nxt        = sum_r;
    bkt_nxt        = bkt_r;
    cur_nxt        = cur_r;
    mis_nxt        = mis_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    bkt_we         = 1'b0;
    bkt_wa         = bkt_r;
    bkt_wd         = {1'b1, used_idx};
    nxt_we         = 1'b0;
    nm_we          = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        bkt_we  = 1'b1;
        bkt_wa  = clr_r;
        bkt_wd  = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == BKT_W'(BUCKET_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          name_nxt   = in_symbol_name[NAME_W-1:0];
          create_nxt = in_create_if_absent;
          sum_nxt    = '0;
          cnt_nxt    = '0;
          state_nxt  = S_SUM;
        end
      end
      S_SUM: begin
        // One name byte per cycle into the byte sum.
        sum_nxt  = sum_r + SUM_W'(name_r[BYTE_BITS-1:0]);
        name_nxt = name_rot;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(NAME_BYTES - 1)) begin
          cnt_nxt   = '0;
          bkt_nxt   = '0;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        // Reduce the sum modulo the bucket count, most significant bit first.
        if (rem_sh >= (BKT_W + 1)'(BUCKET_COUNT)) begin
          bkt_nxt = BKT_W'(rem_sh - (BKT_W + 1)'(BUCKET_COUNT));
        end else begin
          bkt_nxt = rem_sh[BKT_W-1:0];
        end
        sum_nxt = sum_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(SUM_W - 1)) begin
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        state_nxt = S_HEADW;
      end
      S_HEADW: begin
        cur_nxt = bkt_rd_r;
        cnt_nxt = '0;
        mis_nxt = 1'b0;
        if (bkt_rd_r[IDX_W]) begin
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_MISS;
        end
      end
      S_CMP: begin
        // The byte read in the previous cycle is compared in this one.
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r != '0) begin
          name_nxt = name_rot;
          mis_nxt  = mis_r || byte_ne;
        end
        if (cnt_r == STEP_W'(NAME_BYTES)) begin
          cnt_nxt = '0;
          if (!mis_nxt) begin
            res_status_nxt = ST_FOUND;
            res_idx_nxt    = cur_r[IDX_W-1:0];
            state_nxt      = S_EMIT;
          end else if (nxt_rd_r[IDX_W]) begin
            cur_nxt = nxt_rd_r;
            mis_nxt = 1'b0;
          end else begin
            state_nxt = S_MISS;
          end
        end
      end
      S_MISS: begin
        res_idx_nxt = '0;
        priority if (!create_r) begin
          res_status_nxt = ST_ABSENT;
          state_nxt      = S_EMIT;
        end else if (used_r == USED_W'(ENTRY_COUNT)) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_EMIT;
        end else begin
          cnt_nxt   = '0;
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        // Store the name byte by byte; link the entry at the bucket head once.
        nm_we    = 1'b1;
        name_nxt = name_rot;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == '0) begin
          nxt_we = 1'b1;
          bkt_we = 1'b1;
        end
        if (cnt_r == STEP_W'(NAME_BYTES - 1)) begin
          used_nxt       = used_r + 1'b1;
          res_status_nxt = ST_CREATED;
          res_idx_nxt    = used_idx;
          state_nxt      = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_index_nxt  = idx_wide[INDEX_W-1:0];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      clr_r       <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_r       <= clr_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    name_r       <= name_nxt;
    create_r     <= create_nxt;
    sum_r        <= sum_nxt;
    bkt_r        <= bkt_nxt;
    cur_r        <= cur_nxt;
    mis_r        <= mis_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
  end

  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bkt_mem[bkt_wa] <= bkt_wd;
    end
    bkt_rd_r <= bkt_mem[bkt_r];
  end

  always_ff @(posedge clk) begin
    if (nxt_we) begin
      nxt_mem[used_idx] <= bkt_rd_r;
    end
    nxt_rd_r <= nxt_mem[cur_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (nm_we) begin
      nm_mem[nm_wa] <= name_r[BYTE_BITS-1:0];
    end
    nm_rd_r <= nm_mem[nm_ra];
  end

  `SHT_ASSERT_RUN(a_used_bound, used_r <= USED_W'(ENTRY_COUNT), "entry count beyond pool size")
  `SHT_ASSERT_RUN(a_used_on_insert, !$stable(used_r) |-> $past(state_r) == S_INS, "entry count moved outside insert")
  `SHT_ASSERT_RUN(a_accept_starts_hash, in_valid && !in_stall |=> state_r == S_SUM, "accepted word did not start hashing")
  `SHT_ASSERT_RUN(a_emit_loads, state_r == S_EMIT && !out_valid_r |=> out_valid_r && state_r == S_IDLE, "finished result not loaded into free output")
  `SHT_ASSERT_RUN(a_bucket_range, state_r == S_HEAD |-> bkt_r < BKT_W'(BUCKET_COUNT - 1) || bkt_r == BKT_W'(BUCKET_COUNT - 1), "bucket index out of range")

endmodule

@@ tb/symbol_hash_table_lookup_insert_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels of the symbol table, keeps a shadow copy of the table
// and compares each result word with the oldest predicted result.
module symbol_hash_table_lookup_insert_checker
  import symhash_pkg::*;
#(
  parameter int NAME_BYTES   = 8,
  parameter int BUCKET_COUNT = 64,
  parameter int ENTRY_COUNT  = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [NAME_IN_W-1:0] in_symbol_name,
  input  logic                 in_create_if_absent,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  status_t              out_status,
  input  logic [INDEX_W-1:0]   out_entry_index,
  output int                   fail_count,
  output int                   pending_count
);

  typedef struct packed {
    status_t            status;
    logic [INDEX_W-1:0] index;
  } lookup_result_t;

  // Shadow table: bucket heads, stored names and chain links.
  bit                   shadow_head_valid [BUCKET_COUNT];
  int                   shadow_head_idx   [BUCKET_COUNT];
  logic [NAME_IN_W-1:0] shadow_name       [ENTRY_COUNT];
  bit                   shadow_link_valid [ENTRY_COUNT];
  int                   shadow_link_idx   [ENTRY_COUNT];
  int                   shadow_used;

  lookup_result_t expected_results[$];
  int             mismatches = 0;

  function automatic lookup_result_t lookup_or_insert(logic [NAME_IN_W-1:0] raw_name,
                                                      logic create);
    logic [NAME_IN_W-1:0] name;
    int                   byte_sum;
    int                   bucket;
    bit                   cur_valid;
    int                   cur;
    int                   steps;
    lookup_result_t       res;
    name     = '0;
    byte_sum = 0;
    for (int i = 0; i < NAME_BYTES && i < NAME_IN_W / BYTE_BITS; i++) begin
      name[BYTE_BITS*i +: BYTE_BITS] = raw_name[BYTE_BITS*i +: BYTE_BITS];
      byte_sum += raw_name[BYTE_BITS*i +: BYTE_BITS];
    end
    bucket    = byte_sum % BUCKET_COUNT;
    res       = '{status: ST_ABSENT, index: '0};
    cur_valid = shadow_head_valid[bucket];
    cur       = shadow_head_idx[bucket];
    steps     = 0;
    while (cur_valid && cur < ENTRY_COUNT && steps < shadow_used) begin
      if (shadow_name[cur] == name) begin
        res = '{status: ST_FOUND, index: cur[INDEX_W-1:0]};
        return res;
      end
      cur_valid = shadow_link_valid[cur];
      cur       = shadow_link_idx[cur];
      steps++;
    end
    if (create) begin
      if (shadow_used >= ENTRY_COUNT) begin
        res.status = ST_FULL;
      end else begin
        shadow_name[shadow_used]       = name;
        shadow_link_valid[shadow_used] = shadow_head_valid[bucket];
        shadow_link_idx[shadow_used]   = shadow_head_idx[bucket];
        shadow_head_valid[bucket]      = 1'b1;
        shadow_head_idx[bucket]        = shadow_used;
        res = '{status: ST_CREATED, index: shadow_used[INDEX_W-1:0]};
        shadow_used++;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst_n) begin
      for (int b = 0; b < BUCKET_COUNT; b++) begin
        shadow_head_valid[b] = 1'b0;
        shadow_head_idx[b]   = 0;
      end
      shadow_used = 0;
      expected_results.delete();
    end else begin
      // The result side is checked first so that a word accepted at this edge
      // can never be matched against its own result.
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result word with nothing expected, actual status %0d index %0d",
                   $time, out_status, out_entry_index);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_status);
            mismatches++;
          end
          if (out_entry_index !== want.index) begin
            $display("%0t: entry index mismatch, expected %0d, actual %0d",
                     $time, want.index, out_entry_index);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(lookup_or_insert(in_symbol_name, in_create_if_absent));
      end
    end
    fail_count    <= mismatches;
    pending_count <= expected_results.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

// Top level of the symbol table testbench. It resets the block, sends lookup
// words on the input channel, stalls the result channel at random and gives
// the verdict. All checking happens in the checker instance beside the block.
module tb
  import symhash_pkg::*;
();

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [NAME_IN_W-1:0] in_symbol_name;
  logic                 in_create_if_absent;
  logic                 out_valid;
  logic                 out_stall;
  status_t              out_status;
  logic [INDEX_W-1:0]   out_entry_index;
  int                   fail_count;
  int                   pending_count;

  // Names that were sent with create set. They are reused for lookups that
  // should hit, and shuffled to make new names that land in the same bucket.
  logic [NAME_IN_W-1:0] sent_names[$];

  // While a burst flag is set, that side of the handshake never idles.
  bit in_burst;
  bit out_burst;

  symbol_hash_table_lookup_insert i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_symbol_name      (in_symbol_name),
    .in_create_if_absent (in_create_if_absent),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_entry_index     (out_entry_index)
  );

  symbol_hash_table_lookup_insert_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_symbol_name      (in_symbol_name),
    .in_create_if_absent (in_create_if_absent),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_entry_index     (out_entry_index),
    .fail_count          (fail_count),
    .pending_count       (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Gap lengths are mostly zero or short, with the occasional long pause so
  // that idle cycles land in every stage of a lookup.
  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // A random name: usually a short zero-padded name of 1 to 8 characters,
  // sometimes a full 64-bit pattern.
  function automatic logic [NAME_IN_W-1:0] random_name();
    logic [NAME_IN_W-1:0] name;
    int                   len;
    name = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0) begin
      len = $urandom_range(1, 8);
      for (int i = len; i < 8; i++) name[BYTE_BITS*i +: BYTE_BITS] = '0;
    end
    return name;
  endfunction

  // Swapping two bytes keeps the byte sum, so the new name hashes to the same
  // bucket as the old one and grows its chain.
  function automatic logic [NAME_IN_W-1:0] shuffled_name(logic [NAME_IN_W-1:0] name);
    int         a;
    int         b;
    logic [7:0] t;
    a = $urandom_range(0, 7);
    b = $urandom_range(0, 7);
    t = name[BYTE_BITS*a +: BYTE_BITS];
    name[BYTE_BITS*a +: BYTE_BITS] = name[BYTE_BITS*b +: BYTE_BITS];
    name[BYTE_BITS*b +: BYTE_BITS] = t;
    return name;
  endfunction

  // Presents one lookup word and holds it until the block takes it. When the
  // next word follows back to back, in_valid simply stays high; otherwise it
  // drops for the gap and the payload is scrambled to catch a block that
  // samples it while idle.
  task automatic send_word(logic [NAME_IN_W-1:0] name, logic create);
    int gap;
    in_valid            <= 1'b1;
    in_symbol_name      <= name;
    in_create_if_absent <= create;
    do @(posedge clk); while (in_stall);
    if (create) sent_names.push_back(name);
    if ($urandom_range(0, 99) < 3) in_burst = !in_burst;
    gap = pick_gap(in_burst);
    if (gap != 0) begin
      in_valid            <= 1'b0;
      in_symbol_name      <= {$urandom, $urandom};
      in_create_if_absent <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
  endtask

  // The receiver alternates between stall runs of random length and short
  // stretches of readiness; a burst run keeps it ready throughout.
  initial begin
    int hold;
    out_stall = 1'b0;
    out_burst = 1'b0;
    forever begin
      if ($urandom_range(0, 99) < 5) out_burst = !out_burst;
      hold = pick_gap(out_burst);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  initial begin
    logic [NAME_IN_W-1:0] name;
    int                   r;
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_symbol_name      = '0;
    in_create_if_absent = 1'b0;
    in_burst            = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // The block clears its bucket heads after reset with in_stall high, so
    // the first word simply waits on the handshake.

    // Directed words. "A" (0x41) and the two-byte names 0x0140, 0x4001 and
    // 0x2021 all sum to 65 and share one bucket; the empty name, 0x80 and
    // the top-byte-only name share another.
    send_word(64'h41, 1'b0);                  // absent without create
    send_word(64'h41, 1'b1);                  // first insert
    send_word(64'h41, 1'b0);                  // found
    send_word(64'h41, 1'b1);                  // found again, no second insert
    send_word(64'h0, 1'b1);                   // empty name inserted
    send_word(64'h0, 1'b0);
    send_word('1, 1'b1);                      // all ones, highest byte sum
    send_word('1, 1'b0);
    send_word(64'h0140, 1'b1);                // collides with "A"
    send_word(64'h4001, 1'b1);                // chain of three in one bucket
    send_word(64'h41, 1'b0);                  // hit at the tail of the chain
    send_word(64'h0140, 1'b0);                // hit in the middle
    send_word(64'h2021, 1'b0);                // full walk, then absent
    send_word(64'h80, 1'b1);                  // collides with the empty name
    send_word(64'h0, 1'b0);
    send_word(64'h8000_0000_0000_0000, 1'b0); // same bucket, absent
    send_word(64'h0101_0101_0101_0101, 1'b1);
    send_word(64'hFEFF_FFFF_FFFF_FFFF, 1'b1);
    send_word('1, 1'b0);
    send_word(64'h5555_5555_5555_5555, 1'b1);
    send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);

    // Random words. Most of them insert new names, enough to run the entry
    // pool dry so that the table-full case is reached well before the end.
    // The rest revisit names already sent or probe absent names.
    repeat (430) begin
      r = $urandom_range(0, 99);
      if (r < 60 || sent_names.size() == 0) begin
        send_word(random_name(), 1'b1);
      end else if (r < 72) begin
        name = sent_names[$urandom_range(0, sent_names.size() - 1)];
        send_word(shuffled_name(name), 1'b1);
      end else if (r < 90) begin
        name = sent_names[$urandom_range(0, sent_names.size() - 1)];
        send_word(name, 1'($urandom_range(0, 1)));
      end else begin
        send_word(random_name(), 1'b0);
      end
    end

    // The edge waited on here lets the checker count the last accepted word
    // before the wait for outstanding results begins.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("[symbol_hash_table_lookup_insert] OK");
    end else begin
      $display("[symbol_hash_table_lookup_insert] ERROR");
    end
    $finish;
  end

  // Watchdog: several times the slowest expected run, long chain walks and
  // long receiver stalls included.
  initial begin
    #40_000_000;
    $display("[symbol_hash_table_lookup_insert] ERROR");
    $finish;
  end

endmodule
